// File: src/hhfp_pkg.sv
// shared types, keyword table and op codes for the http header field parser
package hhfp_pkg;

    localparam int KW_COUNT = 16;
    localparam int KW_BYTES = 29;
    localparam int QUEUE_DEPTH = 2;
    localparam logic [4:0] FIELD_CONTENT_LENGTH = 5'd8;

    localparam logic [7:0] CHAR_CR = 8'h0d;
    localparam logic [7:0] CHAR_LF = 8'h0a;
    localparam logic [7:0] CHAR_COLON = 8'h3a;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    // keywords right aligned, first character in the highest used byte
    localparam logic [8*KW_BYTES-1:0] KW_TEXT [KW_COUNT] = '{
        "accept", "accept-charset", "accept-encoding", "accept-language",
        "access-control-request-method", "cache-control", "connection",
        "content-length", "content-type", "date", "from", "host", "origin",
        "referer", "user-agent", "upgrade"
    };

    localparam logic [4:0] KW_LEN [KW_COUNT] = '{
        5'd6, 5'd14, 5'd15, 5'd15, 5'd29, 5'd13, 5'd10, 5'd14,
        5'd12, 5'd4, 5'd4, 5'd4, 5'd6, 5'd7, 5'd10, 5'd7
    };

    localparam logic [KW_COUNT-1:0] KW_EXACT = 16'h0001;

    typedef enum logic [1:0] {
        OP_START,
        OP_BYTE,
        OP_END,
        OP_DONE
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
        logic [4:0] field;
    } q_entry_t;

    function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [4:0] i);
        return KW_TEXT[k][8*(int'(KW_LEN[k]) - 1 - int'(i)) +: 8];
    endfunction

endpackage

// File: src/hhfp_front.sv
// front part: name collection, keyword matching and value byte filtering
module hhfp_front
    import hhfp_pkg::*;
#(
    parameter int NAME_MAX = 32
)(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       start_of_header,
    output logic       push,
    output q_entry_t   push_entry
);

    localparam int PW = $clog2(NAME_MAX + 1);

    logic                in_value_reg, in_value_next;
    logic                skip_reg, skip_next;
    logic                cr_reg, cr_next;
    logic                finished_reg, finished_next;
    logic [PW-1:0]       pos_reg, pos_next;
    logic [KW_COUNT-1:0] alive_reg, alive_next;

    logic                cur_in_value, cur_skip, cur_cr, cur_finished;
    logic [PW-1:0]       cur_pos;
    logic [KW_COUNT-1:0] cur_alive;
    logic [4:0]          match_id;

    always_comb
    begin
        cur_in_value = start_of_header ? 1'b0 : in_value_reg;
        cur_skip     = start_of_header ? 1'b0 : skip_reg;
        cur_cr       = start_of_header ? 1'b0 : cr_reg;
        cur_finished = start_of_header ? 1'b0 : finished_reg;
        cur_pos      = start_of_header ? '0 : pos_reg;
        cur_alive    = start_of_header ? '1 : alive_reg;
    end

    // first live keyword in id order whose length fits the name
    always_comb
    begin
        match_id = 5'd0;
        for (int k = KW_COUNT - 1; k >= 0; k--)
        begin
            if (cur_alive[k] && cur_pos >= PW'(KW_LEN[k]) &&
                (!KW_EXACT[k] || cur_pos == PW'(KW_LEN[k])))
            begin
                match_id = 5'(k + 1);
            end
        end
    end

    always_comb
    begin
        in_value_next = in_value_reg;
        skip_next     = skip_reg;
        cr_next       = cr_reg;
        finished_next = finished_reg;
        pos_next      = pos_reg;
        alive_next    = alive_reg;
        push          = 1'b0;
        push_entry    = '{op: OP_BYTE, data: data_byte, field: 5'd0};

        if (accept)
        begin
            in_value_next = cur_in_value;
            skip_next     = cur_skip;
            cr_next       = cur_cr;
            finished_next = cur_finished;
            pos_next      = cur_pos;
            alive_next    = cur_alive;

            if (!cur_finished)
            begin
                if (!cur_in_value)
                begin
                    if (data_byte == CHAR_CR)
                    begin
                        cr_next = 1'b1;
                    end
                    else if (data_byte == CHAR_LF)
                    begin
                        cr_next = 1'b0;
                        if (cur_cr && cur_pos == '0)
                        begin
                            finished_next = 1'b1;
                            push = 1'b1;
                            push_entry.op = OP_DONE;
                        end
                        pos_next   = '0;
                        alive_next = '1;
                    end
                    else if (data_byte == CHAR_COLON)
                    begin
                        cr_next       = 1'b0;
                        in_value_next = 1'b1;
                        skip_next     = 1'b1;
                        pos_next      = '0;
                        alive_next    = '1;
                        push          = 1'b1;
                        push_entry.op    = OP_START;
                        push_entry.field = match_id;
                    end
                    else
                    begin
                        cr_next = 1'b0;
                        if (cur_pos < PW'(NAME_MAX))
                        begin
                            for (int k = 0; k < KW_COUNT; k++)
                            begin
                                if (cur_pos < PW'(KW_LEN[k]) &&
                                    kw_char(4'(k), 5'(cur_pos)) != data_byte)
                                begin
                                    alive_next[k] = 1'b0;
                                end
                            end
                            pos_next = cur_pos + PW'(1);
                        end
                    end
                end
                else
                begin
                    skip_next = 1'b0;
                    if (cur_skip && data_byte == CHAR_SPACE)
                    begin
                        push = 1'b0;
                    end
                    else if (data_byte == CHAR_LF)
                    begin
                        in_value_next = 1'b0;
                        push = 1'b1;
                        push_entry.op = OP_END;
                    end
                    else if (data_byte != CHAR_CR)
                    begin
                        push = 1'b1;
                        push_entry.op = OP_BYTE;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_value_reg <= 1'b0;
            skip_reg     <= 1'b0;
            cr_reg       <= 1'b0;
            finished_reg <= 1'b0;
            pos_reg      <= '0;
            alive_reg    <= '1;
        end
        else
        begin
            in_value_reg <= in_value_next;
            skip_reg     <= skip_next;
            cr_reg       <= cr_next;
            finished_reg <= finished_next;
            pos_reg      <= pos_next;
            alive_reg    <= alive_next;
        end
    end

endmodule

// File: src/hhfp_queue.sv
// two entry queue between the front and back parts
module hhfp_queue
    import hhfp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_entry,
    input  logic     pop,
    output logic     full,
    output logic     not_empty,
    output q_entry_t head
);

    q_entry_t   mem_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'(QUEUE_DEPTH));
    assign not_empty = (count_reg != 2'd0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !not_empty))
        else $error("queue read while empty");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

// File: src/hhfp_back.sv
// back part: value counting, content-length number and result register
module hhfp_back
    import hhfp_pkg::*;
#(
    parameter int VALUE_MAX = 256
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_not_empty,
    input  q_entry_t    q_head,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  field_id,
    output logic [7:0]  value_byte,
    output logic        byte_valid,
    output logic        last_of_value,
    output logic [31:0] length_value,
    output logic        value_truncated,
    output logic        header_done
);

    localparam int CW = $clog2(VALUE_MAX + 1);

    logic [4:0]    field_reg, field_next;
    logic [CW-1:0] count_reg, count_next;
    logic [31:0]   acc_reg, acc_next;
    logic          closed_reg, closed_next;
    logic          trunc_reg, trunc_next;

    logic          valid_reg, valid_next;
    logic [4:0]    id_reg, id_next;
    logic [7:0]    byte_reg, byte_next;
    logic          bvalid_reg, bvalid_next;
    logic          last_reg, last_next;
    logic [31:0]   len_reg, len_next;
    logic          otrunc_reg, otrunc_next;
    logic          done_reg, done_next;

    logic [35:0]   acc_wide;
    logic [3:0]    digit;

    assign pop   = q_not_empty && (!valid_reg || !out_stall);
    assign digit = 4'(q_head.data - CHAR_ZERO);
    assign acc_wide = 36'(acc_reg) * 36'd10 + 36'(digit);

    always_comb
    begin
        field_next  = field_reg;
        count_next  = count_reg;
        acc_next    = acc_reg;
        closed_next = closed_reg;
        trunc_next  = trunc_reg;
        valid_next  = valid_reg && out_stall;
        id_next     = id_reg;
        byte_next   = byte_reg;
        bvalid_next = bvalid_reg;
        last_next   = last_reg;
        len_next    = len_reg;
        otrunc_next = otrunc_reg;
        done_next   = done_reg;

        if (pop)
        begin
            id_next     = field_reg;
            byte_next   = 8'd0;
            bvalid_next = 1'b0;
            last_next   = 1'b0;
            len_next    = 32'd0;
            otrunc_next = 1'b0;
            done_next   = 1'b0;
            unique case (q_head.op)
                OP_START:
                begin
                    field_next  = q_head.field;
                    count_next  = '0;
                    acc_next    = 32'd0;
                    closed_next = 1'b0;
                    trunc_next  = 1'b0;
                end
                OP_BYTE:
                begin
                    if (count_reg >= CW'(VALUE_MAX))
                    begin
                        trunc_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + CW'(1);
                        if (!closed_reg)
                        begin
                            if (q_head.data >= CHAR_ZERO && q_head.data <= CHAR_NINE)
                            begin
                                acc_next = (acc_wide[35:32] != 4'd0) ? 32'hffff_ffff
                                                                     : acc_wide[31:0];
                            end
                            else
                            begin
                                closed_next = 1'b1;
                            end
                        end
                        valid_next  = (field_reg != 5'd0);
                        byte_next   = q_head.data;
                        bvalid_next = 1'b1;
                    end
                end
                OP_END:
                begin
                    valid_next  = (field_reg != 5'd0);
                    last_next   = 1'b1;
                    len_next    = (field_reg == FIELD_CONTENT_LENGTH) ? acc_reg : 32'd0;
                    otrunc_next = trunc_reg;
                    field_next  = 5'd0;
                    count_next  = '0;
                    acc_next    = 32'd0;
                    closed_next = 1'b0;
                    trunc_next  = 1'b0;
                end
                OP_DONE:
                begin
                    valid_next = 1'b1;
                    id_next    = 5'd0;
                    done_next  = 1'b1;
                end
                default:
                begin
                    valid_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_reg  <= 5'd0;
            count_reg  <= '0;
            acc_reg    <= 32'd0;
            closed_reg <= 1'b0;
            trunc_reg  <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            field_reg  <= field_next;
            count_reg  <= count_next;
            acc_reg    <= acc_next;
            closed_reg <= closed_next;
            trunc_reg  <= trunc_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg     <= id_next;
        byte_reg   <= byte_next;
        bvalid_reg <= bvalid_next;
        last_reg   <= last_next;
        len_reg    <= len_next;
        otrunc_reg <= otrunc_next;
        done_reg   <= done_next;
    end

    assign out_valid       = valid_reg;
    assign field_id        = id_reg;
    assign value_byte      = byte_reg;
    assign byte_valid      = bvalid_reg;
    assign last_of_value   = last_reg;
    assign length_value    = len_reg;
    assign value_truncated = otrunc_reg;
    assign header_done     = done_reg;

    a_done_no_id: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && done_reg |-> id_reg == 5'd0 && !bvalid_reg && !last_reg)
        else $error("header end carries field data");
    a_trunc_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && otrunc_reg |-> last_reg)
        else $error("truncation flag outside a last result");
    a_len_only_cl: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && len_reg != 32'd0 |-> last_reg && id_reg == FIELD_CONTENT_LENGTH)
        else $error("length on a result other than content-length end");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(VALUE_MAX))
        else $error("value count past limit");

endmodule

// File: src/http_header_field_parser_core.sv
// HTTP header field parser: one header byte per cycle in, at most one tagged value result
// per byte out; the front part matches the field name against sixteen keywords as the
// bytes arrive and filters value bytes, a two entry queue follows, and the back part
// counts value bytes, builds the content-length number and holds the result in an output
// register, so a new byte is taken every cycle while the queue has room and each result
// is written into a queue entry and then into the output register on its way out.
module http_header_field_parser_core
    import hhfp_pkg::*;
#(
    parameter int NAME_MAX  = 32,
    parameter int VALUE_MAX = 256
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        start_of_header,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  field_id,
    output logic [7:0]  value_byte,
    output logic        byte_valid,
    output logic        last_of_value,
    output logic [31:0] length_value,
    output logic        value_truncated,
    output logic        header_done
);

    logic     accept;
    logic     push;
    logic     pop;
    logic     full;
    logic     not_empty;
    q_entry_t push_entry;
    q_entry_t head;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    hhfp_front #(.NAME_MAX(NAME_MAX)) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .data_byte       (data_byte),
        .start_of_header (start_of_header),
        .push            (push),
        .push_entry      (push_entry)
    );

    hhfp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .not_empty  (not_empty),
        .head       (head)
    );

    hhfp_back #(.VALUE_MAX(VALUE_MAX)) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_not_empty     (not_empty),
        .q_head          (head),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .field_id        (field_id),
        .value_byte      (value_byte),
        .byte_valid      (byte_valid),
        .last_of_value   (last_of_value),
        .length_value    (length_value),
        .value_truncated (value_truncated),
        .header_done     (header_done)
    );

endmodule
